// File: hw/rtl/salru_pkg.sv
// Shared types and constants for the set-associative LRU tag lookup.
package salru_pkg;

    localparam int SETS     = 16;
    localparam int WAYS     = 4;
    localparam int TAG_BITS = 20;
    localparam int SET_BITS = 4;
    localparam int WAY_BITS = 2;

    typedef logic [SET_BITS-1:0] set_t;
    typedef logic [TAG_BITS-1:0] tag_t;
    typedef logic [WAY_BITS-1:0] way_t;

    typedef enum logic [1:0]
    {
        KIND_HIT      = 2'd0,
        KIND_COLD     = 2'd1,
        KIND_CONFLICT = 2'd2
    } kind_t;

    typedef logic [WAYS-1:0][TAG_BITS-1:0] tag_row_t;
    typedef logic [WAYS-1:0][WAY_BITS-1:0] rank_row_t;
    typedef logic [WAYS-1:0]               valid_row_t;

endpackage

// File: hw/rtl/salru_if.sv
// Request and response channel interfaces of the LRU tag lookup.
interface salru_req_if
    import salru_pkg::*;
();
    logic valid;
    logic ready;
    set_t set_index;
    tag_t tag;

    modport source (output valid, output set_index, output tag, input ready);
    modport sink   (input valid, input set_index, input tag, output ready);
endinterface

interface salru_rsp_if
    import salru_pkg::*;
();
    logic  valid;
    logic  ready;
    kind_t access_kind;
    way_t  way;

    modport source (output valid, output access_kind, output way, input ready);
    modport sink   (input valid, input access_kind, input way, output ready);
endinterface

// File: hw/rtl/set_assoc_lru_lookup.sv
// Top level: tag store and true-LRU replacement of a 4-way, 16-set cache.
//
//   channel | dir | payload                  | handshake
//   req     | in  | set_index[3:0], tag[19:0] | valid/ready
//   rsp     | out | access_kind[1:0], way[1:0] | valid/ready
//
// One item per cycle while the result is not stalled; accept loads the input
// register, then compare/update writes the result register. The tag row is read from the
// set-row memory at accept; a write from the item ahead to the same set is
// forwarded. Valid bits are flip-flops cleared by rst_n at once; ranks reset to the way number.
// A stalled result holds the input register; req.ready then stays low.
module set_assoc_lru_lookup
    import salru_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    salru_req_if.sink   req,
    salru_rsp_if.source rsp
);

    tag_row_t   tag_mem [SETS];
    valid_row_t valid_reg [SETS];
    rank_row_t  rank_reg [SETS];

    logic     s1_valid_reg;
    set_t     set_reg;
    tag_t     tag_reg;
    tag_row_t tag_row_reg;

    logic  out_valid_reg;
    kind_t kind_reg;
    way_t  way_reg;

    logic       advance;
    logic       accept;
    valid_row_t vrow;
    rank_row_t  rrow;
    logic       hit;
    way_t       hit_way;
    way_t       victim;
    way_t       pick;
    way_t       old_rank;
    kind_t      kind_next;
    tag_row_t   row_next;
    valid_row_t vrow_next;
    rank_row_t  rrow_next;

    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.access_kind = kind_reg;
    assign rsp.way         = way_reg;

    always_comb
    begin
        vrow     = valid_reg[set_reg];
        rrow     = rank_reg[set_reg];
        hit      = 1'b0;
        hit_way  = '0;
        victim   = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (vrow[w] && tag_row_reg[w] == tag_reg)
            begin
                if (!hit || rrow[w] < rrow[hit_way])
                begin
                    hit_way = WAY_BITS'(w);
                end
                hit = 1'b1;
            end
        end
        for (int w = 1; w < WAYS; w++)
        begin
            if (rrow[w] > rrow[victim])
            begin
                victim = WAY_BITS'(w);
            end
        end
        pick      = hit ? hit_way : victim;
        kind_next = hit ? KIND_HIT : (vrow[victim] ? KIND_CONFLICT : KIND_COLD);
        row_next  = tag_row_reg;
        vrow_next = vrow;
        if (!hit)
        begin
            row_next[victim]  = tag_reg;
            vrow_next[victim] = 1'b1;
        end
        old_rank = rrow[pick];
        for (int w = 0; w < WAYS; w++)
        begin
            rrow_next[w] = (rrow[w] < old_rank) ? rrow[w] + WAY_BITS'(1) : rrow[w];
        end
        rrow_next[pick] = '0;
    end

    // set-row tag memory, registered read with write forwarding
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tag_mem[set_reg] <= row_next;
        end
        if (accept)
        begin
            set_reg <= req.set_index;
            tag_reg <= req.tag;
            if (advance && set_reg == req.set_index)
            begin
                tag_row_reg <= row_next;
            end
            else
            begin
                tag_row_reg <= tag_mem[req.set_index];
            end
        end
        if (advance)
        begin
            kind_reg <= kind_next;
            way_reg  <= pick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < SETS; s++)
            begin
                valid_reg[s] <= '0;
                for (int w = 0; w < WAYS; w++)
                begin
                    rank_reg[s][w] <= WAY_BITS'(w);
                end
            end
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                valid_reg[set_reg] <= vrow_next;
                rank_reg[set_reg]  <= rrow_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/salru_check.sv
// Port-level checks for the LRU tag lookup, bound to the top level.
module salru_check
    import salru_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  req_valid,
    input logic  req_ready,
    input logic  rsp_valid,
    input logic  rsp_ready,
    input kind_t rsp_access_kind,
    input way_t  rsp_way
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_access_kind) && $stable(rsp_way))
        else $error("result changed while stalled");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_access_kind == KIND_HIT || rsp_access_kind == KIND_COLD ||
                       rsp_access_kind == KIND_CONFLICT))
        else $error("bad access kind");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!rsp_valid || rsp_ready) |-> req_ready)
        else $error("request stalled while result side free");

    a_fill_one: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> ##2 rsp_valid)
        else $error("accepted item produced no result");

endmodule

bind set_assoc_lru_lookup salru_check u_salru_check
(
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_access_kind(rsp.access_kind),
    .rsp_way        (rsp.way)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the set-associative true-LRU tag lookup.
module tb;
    import salru_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int POOL_DEPTH = 6;
    localparam int DIRECTED_COUNT = 21;

    typedef struct packed
    {
        kind_t kind;
        way_t  way;
    } lookup_res_t;

    typedef struct packed
    {
        set_t  set_index;
        tag_t  tag;
        logic  known;
        kind_t kind;
        way_t  way;
    } probe_row_t;

    logic clk;
    logic rst_n;
    int   error_count;
    int   cycle_count;

    salru_req_if req_ch();
    salru_rsp_if rsp_ch();

    set_assoc_lru_lookup dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow tag store of the cache.
    tag_t        line_tag   [SETS][WAYS];
    logic        line_valid [SETS][WAYS];
    int unsigned lru_rank   [SETS][WAYS];

    lookup_res_t pending_q[$];
    tag_t        tag_pool [SETS][POOL_DEPTH];

    probe_row_t directed_rows [DIRECTED_COUNT] = '{
        '{4'd0,  20'h00000, 1'b1, KIND_COLD,     2'd3},
        '{4'd0,  20'h00000, 1'b1, KIND_HIT,      2'd3},
        '{4'd0,  20'hFFFFF, 1'b1, KIND_COLD,     2'd2},
        '{4'd0,  20'hAAAAA, 1'b1, KIND_COLD,     2'd1},
        '{4'd0,  20'h55555, 1'b1, KIND_COLD,     2'd0},
        '{4'd0,  20'h00000, 1'b1, KIND_HIT,      2'd3},
        '{4'd0,  20'h12345, 1'b1, KIND_CONFLICT, 2'd2},
        '{4'd0,  20'hFFFFF, 1'b1, KIND_CONFLICT, 2'd1},
        '{4'd15, 20'hFFFFF, 1'b1, KIND_COLD,     2'd3},
        '{4'd15, 20'hFFFFF, 1'b1, KIND_HIT,      2'd3},
        '{4'd5,  20'hAAAAA, 1'b0, KIND_HIT,      2'd0},
        '{4'd10, 20'h55555, 1'b0, KIND_HIT,      2'd0},
        '{4'd5,  20'h55555, 1'b0, KIND_HIT,      2'd0},
        '{4'd10, 20'hAAAAA, 1'b0, KIND_HIT,      2'd0},
        '{4'd5,  20'hAAAAA, 1'b0, KIND_HIT,      2'd0},
        '{4'd15, 20'h00000, 1'b0, KIND_HIT,      2'd0},
        '{4'd15, 20'h00001, 1'b0, KIND_HIT,      2'd0},
        '{4'd15, 20'h00002, 1'b0, KIND_HIT,      2'd0},
        '{4'd15, 20'h80000, 1'b0, KIND_HIT,      2'd0},
        '{4'd15, 20'hFFFFF, 1'b0, KIND_HIT,      2'd0},
        '{4'd0,  20'h12345, 1'b0, KIND_HIT,      2'd0}
    };

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    task automatic clear_shadow();
        for (int s = 0; s < SETS; s++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                line_valid[s][w] = 1'b0;
                lru_rank[s][w]   = w;
            end
        end
    endtask

    // Look up one access in the shadow store and update valid, tag and recency.
    function automatic lookup_res_t predict_lookup(input set_t s, input tag_t t);
        lookup_res_t res;
        bit          hit;
        int          pick;
        int unsigned old_rank;
        hit  = 1'b0;
        pick = 0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (line_valid[s][w] && line_tag[s][w] == t)
            begin
                if (!hit || lru_rank[s][w] < lru_rank[s][pick])
                    pick = w;
                hit = 1'b1;
            end
        end
        if (hit)
        begin
            res.kind = KIND_HIT;
        end
        else
        begin
            pick = 0;
            for (int w = 1; w < WAYS; w++)
            begin
                if (lru_rank[s][w] > lru_rank[s][pick])
                    pick = w;
            end
            res.kind = line_valid[s][pick] ? KIND_CONFLICT : KIND_COLD;
            line_valid[s][pick] = 1'b1;
            line_tag[s][pick]   = t;
        end
        old_rank = lru_rank[s][pick];
        for (int w = 0; w < WAYS; w++)
        begin
            if (lru_rank[s][w] < old_rank)
                lru_rank[s][w]++;
        end
        lru_rank[s][pick] = 0;
        res.way = way_t'(pick);
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic issue_access(input set_t s, input tag_t t, input logic known = 1'b0,
                                input kind_t known_kind = KIND_HIT,
                                input way_t known_way = '0);
        lookup_res_t res;
        req_ch.valid     <= 1'b1;
        req_ch.set_index <= s;
        req_ch.tag       <= t;
        do
            @(posedge clk);
        while (!req_ch.ready);
        res = predict_lookup(s, t);
        if (known)
        begin
            res.kind = known_kind;
            res.way  = known_way;
        end
        pending_q.push_back(res);
        @(negedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        lookup_res_t exp_res;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_q.size() == 0)
            begin
                report_mismatch($sformatf("result kind %0d way %0d with no access pending",
                                          rsp_ch.access_kind, rsp_ch.way));
            end
            else
            begin
                exp_res = pending_q.pop_front();
                if (rsp_ch.access_kind !== exp_res.kind)
                    report_mismatch($sformatf("access_kind %0d, expected %0d",
                                              rsp_ch.access_kind, exp_res.kind));
                if (rsp_ch.way !== exp_res.way)
                    report_mismatch($sformatf("way %0d, expected %0d",
                                              rsp_ch.way, exp_res.way));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: stretches of always-ready, coin-flip, mostly-stalled and periodic.
    initial
    begin
        int mode;
        int stretch;
        int period;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(10, 60);
            period  = $urandom_range(2, 5);
            for (int i = 0; i < stretch; i++)
            begin
                @(negedge clk);
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= (i % period == 0);
                endcase
            end
        end
    end

    initial
    begin
        int   burst_left;
        set_t s;
        tag_t t;
        error_count      = 0;
        cycle_count      = 0;
        rst_n            = 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.set_index <= '0;
        req_ch.tag       <= '0;
        clear_shadow();
        for (int si = 0; si < SETS; si++)
            for (int p = 0; p < POOL_DEPTH; p++)
                tag_pool[si][p] = tag_t'($urandom);
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            issue_access(directed_rows[i].set_index, directed_rows[i].tag,
                         directed_rows[i].known, directed_rows[i].kind,
                         directed_rows[i].way);
            if ($urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 3));
        end

        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            if (n % 200 == 199)
            begin
                s = set_t'($urandom_range(0, SETS - 1));
                for (int p = 0; p < POOL_DEPTH; p++)
                    tag_pool[s][p] = tag_t'($urandom);
            end
            s = set_t'($urandom_range(0, SETS - 1));
            if ($urandom_range(0, 99) < 85)
                t = tag_pool[s][$urandom_range(0, POOL_DEPTH - 1)];
            else
                t = tag_t'($urandom);
            issue_access(s, t);
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 2) != 0)
                    idle_sender($urandom_range(1, 6));
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
